// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the priority queue.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk_i, switched off while rst_ni is low.
`define PQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Concurrent assertion sampled on clk_i that also holds during reset.
`define PQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/mpq_pkg.sv =====
// Package of the min priority queue: sizes, codes and transfer structs.
// No dependencies; used by every module of the block.
package mpq_pkg;

  // Number of storage cells in the chain.
  localparam int unsigned DEPTH = 8;
  // Width of the internal fill count, able to hold DEPTH itself.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // Width of the entry count reported with each result.
  localparam int unsigned ENTRY_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    op_e   opcode;
    data_t data_value;
  } pq_in_t;

  typedef struct packed {
    status_e            status;
    data_t              removed_value;
    logic [ENTRY_W-1:0] entry_count;
  } pq_out_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic  ins;
    logic  del;
    data_t value;
  } cell_cmd_t;

endpackage

// ===== src/mpq_cell.sv =====
// One cell of the sorted storage chain of the min priority queue.
// Depends on mpq_pkg for the data type and the command struct.
module mpq_cell import mpq_pkg::*; (
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      occ_i,
  input  logic      left_keep_i,
  input  data_t     left_value_i,
  input  data_t     right_value_i,
  output logic      keep_o,
  output data_t     value_o
);

  data_t value_q, value_d;

  // The cell keeps its entry on insert when it holds a value no larger than
  // the new one, so equal values stay in arrival order.
  assign keep_o = occ_i && !(cmd_i.value < value_q);

  // Insert: the new value lands in the first cell that does not keep, and the
  // cells behind it take their left neighbour's entry. Delete: shift left.
  always_comb begin
    value_d = value_q;
    if (cmd_i.ins && !keep_o) begin
      value_d = left_keep_i ? cmd_i.value : left_value_i;
    end else if (cmd_i.del) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ===== src/min_priority_queue.sv =====
// Top level of the min priority queue: a sorted chain of mpq_cell entries.
// Depends on mpq_pkg and mpq_cell.
//
//   channel   direction  ports                  transfer when
//   command   in         start, busy, in_i      start high and busy low
//   result    out        done_o, res_o          done_o high, one cycle
//
// Every command is taken as it is issued; its result appears on the following
// cycle for exactly one cycle. busy stays low, so a command may be issued on
// every cycle: the cell chain updates all entries in the same cycle, which
// sets this rate. The receiver cannot stall the result. Reset empties the
// queue at once; no clearing pass is needed.
module min_priority_queue import mpq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  pq_in_t  in_i,
  output logic    done_o,
  output pq_out_t res_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q;
  pq_out_t          res_q, res_d;
  logic             accept;
  logic             full, empty;
  cell_cmd_t        cmd;
  logic  [DEPTH-1:0] keep;
  data_t [DEPTH-1:0] value;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);

  // Command to the chain, gated so that refused items leave the state alone.
  assign cmd.ins   = accept && (in_i.opcode == OP_INSERT) && !full;
  assign cmd.del   = accept && (in_i.opcode == OP_DELETE) && !empty;
  assign cmd.value = in_i.data_value;

  // The chain of cells; the head always holds the smallest entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic  left_keep;
    data_t left_value;
    data_t right_value;

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_value = in_i.data_value;
    end else begin : g_body
      assign left_keep  = keep[i-1];
      assign left_value = value[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = value[i];
    end else begin : g_inner
      assign right_value = value[i+1];
    end

    mpq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (CNT_W'(i) < count_q),
      .left_keep_i  (left_keep),
      .left_value_i (left_value),
      .right_value_i(right_value),
      .keep_o       (keep[i]),
      .value_o      (value[i])
    );
  end

  // Fill count and the result of the accepted command.
  always_comb begin
    count_d             = count_q;
    res_d.status        = ST_OK;
    res_d.removed_value = '0;
    if (in_i.opcode == OP_INSERT) begin
      if (full) begin
        res_d.status = ST_OVERFLOW;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        res_d.status = ST_EMPTY;
      end else begin
        count_d             = count_q - CNT_W'(1);
        res_d.removed_value = value[0];
      end
    end
    res_d.entry_count = count_d[ENTRY_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Result payload register, loaded on each transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== src/mpq_checker.sv =====
// Port-level checker of the min priority queue, bound to the top level.
// Depends on mpq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mpq_checker import mpq_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    done_o,
  input pq_out_t res_o
);

  logic ovf_seen, empty_seen, full_count, empty_clean;

  // Conditions on the result currently shown on the ports.
  assign ovf_seen    = done_o && (res_o.status == ST_OVERFLOW);
  assign empty_seen  = done_o && (res_o.status == ST_EMPTY);
  assign full_count  = (res_o.entry_count == ENTRY_W'(DEPTH));
  assign empty_clean = (res_o.entry_count == '0) && (res_o.removed_value == '0);

  // Each command transfer gives a result on the next cycle, and only then.
  `PQ_ASSERT(a_result_follows, (start && !busy) |=> done_o, "missing result")
  `PQ_ASSERT(a_no_stray_result, !(start && !busy) |=> !done_o, "stray result")
  // An overflow is only reported on a full queue.
  `PQ_ASSERT(a_overflow_full, ovf_seen |-> full_count, "overflow below full")
  // An empty report carries a zero value and a zero count.
  `PQ_ASSERT(a_empty_zero, empty_seen |-> empty_clean, "bad empty result")
  // Once reset has been seen at a clock edge, no result is shown on the next cycle.
  `PQ_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |=> !done_o, "result in reset")

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (.*);
